@@ hw/rtl/bsc_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the barometric compensation core.
// No dependencies.
package bsc_pkg;

	// word widths on the stream ports
	localparam int IN_W   = 56;
	localparam int OUT_W  = 88;
	localparam int CFG_W  = 64;
	localparam int CIDX_W = 3;

	// pipeline layout
	localparam int DIV_STEPS = 64;                 // one quotient bit per stage
	localparam int STG_TEMP  = 4;                  // temperature result ready
	localparam int STG_HUM   = 11;                 // humidity result ready
	localparam int STG_DPREP = 10;                 // divider operand prep
	localparam int STG_DIVQ  = STG_DPREP + DIV_STEPS; // last quotient step
	localparam int NS        = STG_DIVQ + 5;       // final stage (output)

	// compensation constants
	localparam logic signed [32:0] T_FINE_P_OFS = 33'sd128000;
	localparam logic signed [31:0] T_FINE_H_OFS = 32'sd76800;
	localparam logic [20:0]        P_FULL       = 21'd1048576;
	localparam logic signed [63:0] P_DIV_SCALE  = 64'sd3125;
	localparam logic signed [63:0] P_ONE_47     = 64'sh0000_8000_0000_0000;
	localparam logic signed [31:0] H_CLAMP      = 32'sd419430400;
	localparam logic signed [31:0] H_MID        = 32'sd2097152;
	localparam logic signed [31:0] H_RND_R      = 32'sd8192;
	localparam logic signed [31:0] H_RND_L      = 32'sd16384;
	localparam logic signed [31:0] H_OFS_I      = 32'sd32768;

	// configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		REG_TEMP_CALIB  = 3'd0,
		REG_PRESS_LOW   = 3'd1,
		REG_PRESS_HIGH  = 3'd2,
		REG_MIXED_CALIB = 3'd3,
		REG_HUM_CALIB   = 3'd4,
		REG_HAS_HUM     = 3'd5
	} cfg_reg_t;

endpackage

@@ hw/rtl/baro_sensor_compensation_core.sv @@
`timescale 1ns / 1ps
// Barometric/thermal/humidity integer compensation core, fully pipelined.
// Depends on bsc_pkg.
//
// channel   | dir | word
// ----------+-----+-------------------------------------------------------
// s_axis    | in  | raw_pressure[19:0] raw_temperature[39:20] raw_humidity[55:40]
// m_axis    | out | temp_centi[31:0] pressure_q24_8[63:32] humidity_q22_10[80:64]
// cfg       | in  | write enable, register index, 64-bit write data
//
// One word enters per cycle while the skid register is empty; the longest path is the
// one-bit-per-stage pressure divider. A two-entry output (stage 79 plus a skid register) lets the
// pipe take one more word after the consumer stalls; while the skid register is
// full the whole pipe holds. Reset clears valid bits and calibration registers.
module baro_sensor_compensation_core
	import bsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_W-1:0]   s_axis_tdata,  // raw_pressure, raw_temperature, raw_humidity
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata,  // temp_centi, pressure_q24_8, humidity_q22_10, pad
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	// ---------------- configuration ----------------
	logic [47:0] temp_calib_q;
	logic [63:0] press_low_q;
	logic [63:0] press_high_q;
	logic [47:0] mixed_calib_q;
	logic [31:0] hum_calib_q;
	logic        has_hum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q  <= '0;
			press_low_q   <= '0;
			press_high_q  <= '0;
			mixed_calib_q <= '0;
			hum_calib_q   <= '0;
			has_hum_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_TEMP_CALIB:  temp_calib_q  <= cfg_wdata[47:0];
				REG_PRESS_LOW:   press_low_q   <= cfg_wdata;
				REG_PRESS_HIGH:  press_high_q  <= cfg_wdata;
				REG_MIXED_CALIB: mixed_calib_q <= cfg_wdata[47:0];
				REG_HUM_CALIB:   hum_calib_q   <= cfg_wdata[31:0];
				REG_HAS_HUM:     has_hum_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// coefficient fields
	logic        [15:0] t1, p1;
	logic signed [31:0] t2, t3;
	logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
	logic signed [31:0] h1, h2, h3, h4, h5, h6;

	assign t1 = temp_calib_q[15:0];
	assign t2 = {{16{temp_calib_q[31]}}, temp_calib_q[31:16]};
	assign t3 = {{16{temp_calib_q[47]}}, temp_calib_q[47:32]};
	assign p1 = press_low_q[15:0];
	assign p2 = press_low_q[31:16];
	assign p3 = press_low_q[47:32];
	assign p4 = press_low_q[63:48];
	assign p5 = press_high_q[15:0];
	assign p6 = press_high_q[31:16];
	assign p7 = press_high_q[47:32];
	assign p8 = press_high_q[63:48];
	assign p9 = mixed_calib_q[15:0];
	assign h1 = {24'd0, mixed_calib_q[23:16]};
	assign h2 = {{16{mixed_calib_q[39]}}, mixed_calib_q[39:24]};
	assign h3 = {24'd0, mixed_calib_q[47:40]};
	assign h4 = {20'd0, hum_calib_q[11:0]};
	assign h5 = {20'd0, hum_calib_q[23:12]};
	assign h6 = {{24{hum_calib_q[31]}}, hum_calib_q[31:24]};

	// ---------------- flow control ----------------
	logic          adv;
	logic [NS:1]   vld_q;
	logic          sk_vld_q;
	logic [OUT_W-1:0] sk_data_q;
	logic [OUT_W-1:0] out_w;

	assign adv           = !sk_vld_q;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = sk_vld_q || vld_q[NS];
	assign m_axis_tdata  = sk_vld_q ? sk_data_q : out_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			sk_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_q <= {vld_q[NS-1:1], s_axis_tvalid};
			end
			if (sk_vld_q) begin
				if (m_axis_tready) begin
					sk_vld_q <= 1'b0;
				end
			end else if (vld_q[NS] && !m_axis_tready) begin
				sk_vld_q <= 1'b1;
			end
		end
	end

	// skid capture of a final word that was not taken
	always_ff @(posedge clk) begin
		if (!sk_vld_q && vld_q[NS] && !m_axis_tready) begin
			sk_data_q <= out_w;
		end
	end

	// ---------------- temperature and front stages ----------------
	logic signed [31:0] d1, d2;
	logic signed [31:0] m1_s1, sq_s1, v1_s2, m3_s2, fine_s3;
	logic        [19:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7;
	logic        [15:0] rh_s1, rh_s2, rh_s3, rh_s4;
	logic signed [32:0] a_s4;
	logic signed [31:0] x_s4;
	logic signed [31:0] temp_s [STG_TEMP:NS];

	assign d1 = {15'd0, s_axis_tdata[39:23]} - {15'd0, t1, 1'b0};
	assign d2 = {16'd0, s_axis_tdata[39:24]} - {16'd0, t1};

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1: first products
			m1_s1 <= d1 * t2;
			sq_s1 <= d2 * d2;
			rp_s1 <= s_axis_tdata[19:0];
			rh_s1 <= s_axis_tdata[55:40];
			// stage 2
			v1_s2 <= m1_s1 >>> 11;
			m3_s2 <= (sq_s1 >>> 12) * t3;
			rp_s2 <= rp_s1;
			rh_s2 <= rh_s1;
			// stage 3: fine temperature
			fine_s3 <= v1_s2 + (m3_s2 >>> 14);
			rp_s3   <= rp_s2;
			rh_s3   <= rh_s2;
			// stage 4: temperature out, offsets for the other paths
			temp_s[STG_TEMP] <= ((fine_s3 <<< 2) + fine_s3 + 32'sd128) >>> 8;
			a_s4  <= {fine_s3[31], fine_s3} - T_FINE_P_OFS;
			x_s4  <= fine_s3 - T_FINE_H_OFS;
			rp_s4 <= rp_s3;
			rh_s4 <= rh_s3;
		end
	end

	// ---------------- pressure operands ----------------
	logic signed [65:0] aa_full;
	logic signed [63:0] aa_s5;
	logic signed [48:0] ap5_s5, ap2_s5;
	logic signed [63:0] b0_s6, c3_s6, sh5_s6, sh2_s6;
	logic signed [63:0] b_s7, a2_s7;
	logic signed [63:0] prod_s8, num0_s8;
	logic signed [63:0] den_s9, num_s9;
	logic        [20:0] pdiff;
	logic        [63:0] ua_s10, ub_s10;

	assign aa_full = a_s4 * a_s4;
	assign pdiff   = P_FULL - {1'b0, rp_s7};

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 5
			aa_s5  <= aa_full[63:0];
			ap5_s5 <= a_s4 * p5;
			ap2_s5 <= a_s4 * p2;
			rp_s5  <= rp_s4;
			// stage 6
			b0_s6  <= aa_s5 * p6;
			c3_s6  <= aa_s5 * p3;
			sh5_s6 <= {{15{ap5_s5[48]}}, ap5_s5} << 17;
			sh2_s6 <= {{15{ap2_s5[48]}}, ap2_s5} << 12;
			rp_s6  <= rp_s5;
			// stage 7
			b_s7  <= b0_s6 + sh5_s6 + ({{48{p4[15]}}, p4} << 35);
			a2_s7 <= (c3_s6 >>> 8) + sh2_s6;
			rp_s7 <= rp_s6;
			// stage 8
			prod_s8 <= (P_ONE_47 + a2_s7) * $signed({48'd0, p1});
			num0_s8 <= ({43'd0, pdiff} << 31) - b_s7;
			// stage 9
			den_s9 <= prod_s8 >>> 33;
			num_s9 <= num0_s8 * P_DIV_SCALE;
			// stage 10: magnitudes for the divider
			ua_s10 <= num_s9[63] ? 64'(-num_s9) : num_s9;
			ub_s10 <= den_s9[63] ? 64'(-den_s9) : den_s9;
		end
	end

	// sign and zero-divisor flags ride along
	logic neg_s [STG_DPREP:STG_DIVQ];
	logic dz_s  [STG_DPREP:NS-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s[STG_DPREP] <= num_s9[63] ^ den_s9[63];
			dz_s[STG_DPREP]  <= (den_s9 == 64'sd0);
		end
	end

	// ---------------- restoring divider, one bit per stage ----------------
	logic [63:0] div_rem_s [1:DIV_STEPS];
	logic [63:0] div_dq_s  [1:DIV_STEPS];
	logic [63:0] div_ub_s  [1:DIV_STEPS];

	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
		logic [63:0] rem_in, dq_in, ub_in;
		logic [64:0] trial;
		logic        ge;
		if (j == 1) begin : g_first
			assign rem_in = '0;
			assign dq_in  = ua_s10;
			assign ub_in  = ub_s10;
		end else begin : g_next
			assign rem_in = div_rem_s[j-1];
			assign dq_in  = div_dq_s[j-1];
			assign ub_in  = div_ub_s[j-1];
		end
		assign trial = {rem_in, dq_in[63]};
		assign ge    = (trial >= {1'b0, ub_in});
		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s[j] <= ge ? 64'(trial - {1'b0, ub_in}) : trial[63:0];
				div_dq_s[j]  <= {dq_in[62:0], ge};
				div_ub_s[j]  <= ub_in;
			end
		end
	end

	for (genvar k = STG_DPREP + 1; k <= STG_DIVQ; k++) begin : g_neg
		always_ff @(posedge clk) begin
			if (adv) begin
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	for (genvar k = STG_DPREP + 1; k <= NS - 1; k++) begin : g_dz
		always_ff @(posedge clk) begin
			if (adv) begin
				dz_s[k] <= dz_s[k-1];
			end
		end
	end

	// ---------------- pressure tail ----------------
	logic signed [63:0] p_s [STG_DIVQ+1:NS-1];
	logic signed [63:0] e_s [STG_DIVQ+2:NS-1];
	logic signed [63:0] q_w, pq_s76, q_s76, c_s78;
	logic        [63:0] ll_s77;
	logic        [31:0] hl_s77, lh_s77;
	logic signed [63:0] psum, pres64;
	logic        [31:0] pres_s79;

	assign q_w = p_s[STG_DIVQ+1] >>> 13;

	always_ff @(posedge clk) begin
		if (adv) begin
			// apply quotient sign
			p_s[STG_DIVQ+1] <= neg_s[STG_DIVQ] ? $signed(64'(-div_dq_s[DIV_STEPS]))
			                                   : $signed(div_dq_s[DIV_STEPS]);
			// first products of the correction terms
			pq_s76          <= q_w * p9;
			q_s76           <= q_w;
			e_s[STG_DIVQ+2] <= p_s[STG_DIVQ+1] * p8;
			p_s[STG_DIVQ+2] <= p_s[STG_DIVQ+1];
			// 64x64 low half as three 32x32 partial products
			ll_s77          <= {32'd0, pq_s76[31:0]} * {32'd0, q_s76[31:0]};
			hl_s77          <= pq_s76[63:32] * q_s76[31:0];
			lh_s77          <= pq_s76[31:0] * q_s76[63:32];
			e_s[STG_DIVQ+3] <= e_s[STG_DIVQ+2];
			p_s[STG_DIVQ+3] <= p_s[STG_DIVQ+2];
			// recombine
			c_s78           <= $signed(ll_s77 + {hl_s77 + lh_s77, 32'd0}) >>> 25;
			e_s[STG_DIVQ+4] <= e_s[STG_DIVQ+3];
			p_s[STG_DIVQ+4] <= p_s[STG_DIVQ+3];
			// final sum
			pres_s79 <= dz_s[NS-1] ? 32'd0 : pres64[31:0];
		end
	end

	// P8 term is scaled down by 2^19 before the sum
	always_comb begin
		psum   = p_s[NS-1] + c_s78 + (e_s[NS-1] >>> 19);
		pres64 = (psum >>> 8) + ({{48{p7[15]}}, p7} << 4);
	end

	// ---------------- humidity ----------------
	logic signed [31:0] mh5_s5, xh6_s5, xh3_s5, base_s5;
	logic signed [31:0] left_s6, inner_s6, left_s7, r0_s7;
	logic signed [31:0] right_w, xx_s8, xx_s9, ss_s9, xx_s10, t_s10;
	logic signed [31:0] hy;
	logic        [16:0] hum_w;
	logic        [16:0] hum_s [STG_HUM:NS];

	assign right_w = (r0_s7 + H_RND_R) >>> 14;

	always_ff @(posedge clk) begin
		if (adv) begin
			mh5_s5   <= h5 * x_s4;
			xh6_s5   <= x_s4 * h6;
			xh3_s5   <= x_s4 * h3;
			base_s5  <= ($signed({16'd0, rh_s4}) <<< 14) - (h4 <<< 20) + H_RND_L;
			left_s6  <= (base_s5 - mh5_s5) >>> 15;
			inner_s6 <= (xh6_s5 >>> 10) * ((xh3_s5 >>> 11) + H_OFS_I);
			left_s7  <= left_s6;
			r0_s7    <= ((inner_s6 >>> 10) + H_MID) * h2;
			xx_s8    <= left_s7 * right_w;
			xx_s9    <= xx_s8;
			ss_s9    <= (xx_s8 >>> 15) * (xx_s8 >>> 15);
			xx_s10   <= xx_s9;
			t_s10    <= (ss_s9 >>> 7) * h1;
			hum_s[STG_HUM] <= hum_w;
		end
	end

	// clamp to 0..100 %RH (zero without the humidity channel) and drop 12 fraction bits
	always_comb begin
		hy = xx_s10 - (t_s10 >>> 4);
		if (!has_hum_q || hy < 32'sd0) begin
			hum_w = '0;
		end else if (hy > H_CLAMP) begin
			hum_w = H_CLAMP[28:12];
		end else begin
			hum_w = hy[28:12];
		end
	end

	// ---------------- result delay lines ----------------
	for (genvar k = STG_TEMP + 1; k <= NS; k++) begin : g_temp
		always_ff @(posedge clk) begin
			if (adv) begin
				temp_s[k] <= temp_s[k-1];
			end
		end
	end

	for (genvar k = STG_HUM + 1; k <= NS; k++) begin : g_hum
		always_ff @(posedge clk) begin
			if (adv) begin
				hum_s[k] <= hum_s[k-1];
			end
		end
	end

	assign out_w = {7'd0, hum_s[NS], pres_s79, temp_s[NS]};

	// ---------------- assertions ----------------
	a_hum_absent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !has_hum_q |-> m_axis_tdata[80:64] == 17'd0)
		else $error("humidity nonzero without humidity channel");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NS] |-> hum_s[NS] <= 17'd102400)
		else $error("humidity above clamp");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sk_vld_q && !m_axis_tready |=> sk_vld_q && $stable(sk_data_q))
		else $error("skid word lost while stalled");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_vld_q) |-> $past(vld_q[NS] && !m_axis_tready))
		else $error("skid filled without a stalled final word");

endmodule

@@ tb/sv/tb_baro_sensor_compensation_core.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the barometric compensation core: random and directed
// raw sample sets under several calibration sets, checked against a local predictor.
// Depends on bsc_pkg and baro_sensor_compensation_core.
module tb_baro_sensor_compensation_core;
	import bsc_pkg::*;

	localparam logic [CIDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CIDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_WAIT  = 100;

	typedef struct packed {
		logic [31:0] temp_centi;
		logic [31:0] pressure_q24_8;
		logic [16:0] humidity_q22_10;
	} reading_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              cfg_we = 1'b0;
	logic [CIDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0]  cfg_wdata = '0;

	baro_sensor_compensation_core DUT (.*);

	// shadow calibration
	logic [63:0] sh_temp, sh_plow, sh_phigh, sh_mixed, sh_hum;
	logic        sh_has_hum;

	logic [IN_W-1:0] raw_pending[$];
	reading_t        readings_due[$];
	bit  running = 0;
	bit  in_acc = 0, out_acc = 0;
	bit  idle_on = 0;
	int  in_gap = 0, out_gap = 0, hold_left = 0;
	int  errors = 0, quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] asr32(logic [31:0] v, int s);
		return $unsigned($signed(v) >>> s);
	endfunction

	function automatic logic [63:0] asr64(logic [63:0] v, int s);
		return $unsigned($signed(v) >>> s);
	endfunction

	function automatic logic [63:0] sext16(logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// signed divide truncating toward zero, overflow wraps
	function automatic logic [63:0] div_trunc(logic [63:0] a, logic [63:0] b);
		logic [63:0] ua, ub, q;
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		q = ua / ub;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	function automatic reading_t compensate(logic [IN_W-1:0] w);
		logic [31:0] adc_p, adc_t, adc_h, t1, t2, t3, h1, h2, h3, h4, h5, h6;
		logic [31:0] d1, v1, d2, v2, fine, x, left, inner, right, s;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, q, c, e;
		reading_t r;
		adc_p = {12'd0, w[19:0]};
		adc_t = {12'd0, w[39:20]};
		adc_h = {16'd0, w[55:40]};
		t1 = {16'd0, sh_temp[15:0]};
		t2 = 32'(sext16(sh_temp[31:16]));
		t3 = 32'(sext16(sh_temp[47:32]));
		p1 = {48'd0, sh_plow[15:0]};
		p2 = sext16(sh_plow[31:16]);
		p3 = sext16(sh_plow[47:32]);
		p4 = sext16(sh_plow[63:48]);
		p5 = sext16(sh_phigh[15:0]);
		p6 = sext16(sh_phigh[31:16]);
		p7 = sext16(sh_phigh[47:32]);
		p8 = sext16(sh_phigh[63:48]);
		p9 = sext16(sh_mixed[15:0]);
		h1 = {24'd0, sh_mixed[23:16]};
		h2 = 32'(sext16(sh_mixed[39:24]));
		h3 = {24'd0, sh_mixed[47:40]};
		h4 = {20'd0, sh_hum[11:0]};
		h5 = {20'd0, sh_hum[23:12]};
		h6 = {{24{sh_hum[31]}}, sh_hum[31:24]};

		// temperature and fine temperature, 32-bit wrap
		d1 = (adc_t >> 3) - (t1 << 1);
		v1 = asr32(d1 * t2, 11);
		d2 = (adc_t >> 4) - t1;
		v2 = asr32(asr32(d2 * d2, 12) * t3, 14);
		fine = v1 + v2;
		r.temp_centi = asr32(fine * 32'd5 + 32'd128, 8);

		// pressure, 64-bit wrap; zero divisor gives zero
		r.pressure_q24_8 = '0;
		a = {{32{fine[31]}}, fine} - 64'd128000;
		b = a * a * p6;
		b = b + ((a * p5) << 17);
		b = b + (p4 << 35);
		a = asr64(a * a * p3, 8) + ((a * p2) << 12);
		a = asr64(((64'd1 << 47) + a) * p1, 33);
		if (a != 0) begin
			p = 64'd1048576 - {32'd0, adc_p};
			p = div_trunc(((p << 31) - b) * 64'd3125, a);
			q = asr64(p, 13);
			c = asr64(p9 * q * q, 25);
			e = asr64(p8 * p, 19);
			p = asr64(p + c + e, 8) + (p7 << 4);
			r.pressure_q24_8 = p[31:0];
		end

		// humidity, 32-bit wrap, clamped
		r.humidity_q22_10 = '0;
		if (sh_has_hum) begin
			x = fine - 32'd76800;
			left = asr32((adc_h << 14) - (h4 << 20) - (h5 * x) + 32'd16384, 15);
			inner = asr32(x * h6, 10) * (asr32(x * h3, 11) + 32'd32768);
			right = asr32((asr32(inner, 10) + 32'd2097152) * h2 + 32'd8192, 14);
			x = left * right;
			s = asr32(x, 15);
			x = x - asr32(asr32(s * s, 7) * h1, 4);
			if (x[31])
				x = 0;
			if (x > 32'd419430400)
				x = 32'd419430400;
			r.humidity_q22_10 = 17'(x >> 12);
		end
		return r;
	endfunction

	function automatic int draw_gap();
		return idle_on ? $urandom_range(0, 12) : 0;
	endfunction

	// input driver
	always @(negedge clk) begin
		if (running) begin
			if (in_acc)
				in_gap = draw_gap();
			if (!s_axis_tvalid || in_acc) begin
				if (in_gap != 0) begin
					in_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (raw_pending.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= raw_pending.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// output ready, with the long hold-off counted here
	always @(negedge clk) begin
		if (running) begin
			if (out_acc)
				out_gap = draw_gap();
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (out_gap != 0) begin
				out_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// monitor, predictor hookup and watchdog
	always @(posedge clk) begin
		reading_t got, want;
		if (running) begin
			in_acc = s_axis_tvalid && s_axis_tready;
			out_acc = m_axis_tvalid && m_axis_tready;
			if (in_acc)
				readings_due.push_back(compensate(s_axis_tdata));
			if (out_acc) begin
				got.temp_centi = m_axis_tdata[31:0];
				got.pressure_q24_8 = m_axis_tdata[63:32];
				got.humidity_q22_10 = m_axis_tdata[80:64];
				if (readings_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected word %h", $time, m_axis_tdata);
				end else begin
					want = readings_due.pop_front();
					if (got.temp_centi !== want.temp_centi) begin
						errors++;
						$display("%0t: temp_centi exp %h got %h", $time,
							want.temp_centi, got.temp_centi);
					end
					if (got.pressure_q24_8 !== want.pressure_q24_8) begin
						errors++;
						$display("%0t: pressure_q24_8 exp %h got %h", $time,
							want.pressure_q24_8, got.pressure_q24_8);
					end
					if (got.humidity_q22_10 !== want.humidity_q22_10) begin
						errors++;
						$display("%0t: humidity_q22_10 exp %h got %h", $time,
							want.humidity_q22_10, got.humidity_q22_10);
					end
				end
			end
			quiet_cycles = (in_acc || out_acc) ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[baro_sensor_compensation_core] ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_TEMP_CALIB:  sh_temp = val & 64'hFFFF_FFFF_FFFF;
			REG_PRESS_LOW:   sh_plow = val;
			REG_PRESS_HIGH:  sh_phigh = val;
			REG_MIXED_CALIB: sh_mixed = val & 64'hFFFF_FFFF_FFFF;
			REG_HUM_CALIB:   sh_hum = val & 64'hFFFF_FFFF;
			REG_HAS_HUM:     sh_has_hum = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// waits until every queued word is sent and every expected reading received, then a margin
	task automatic wait_drained();
		while (raw_pending.size() != 0 || s_axis_tvalid || readings_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic load_typical(bit hum_on);
		write_reg(REG_TEMP_CALIB, {16'hFC18, 16'd26435, 16'd27504});
		write_reg(REG_PRESS_LOW, {16'd2855, 16'd3024, 16'hD643, 16'd36477});
		write_reg(REG_PRESS_HIGH, {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140});
		write_reg(REG_MIXED_CALIB, {8'd0, 16'd362, 8'd75, 16'd6000});
		write_reg(REG_HUM_CALIB, {8'd30, 12'd50, 12'd313});
		write_reg(REG_HAS_HUM, {63'd0, hum_on});
	endtask

	function automatic logic [IN_W-1:0] raw_word(logic [19:0] p, logic [19:0] t,
			logic [15:0] h);
		return {h, t, p};
	endfunction

	// half plausible readings, half anywhere in range
	function automatic logic [IN_W-1:0] random_raw();
		if ($urandom_range(0, 1))
			return raw_word(20'($urandom()), 20'($urandom()), 16'($urandom()));
		return raw_word(20'd415148 + 20'($urandom_range(0, 131071)) - 20'd65536,
			20'd519888 + 20'($urandom_range(0, 131071)) - 20'd65536,
			16'($urandom_range(15000, 45000)));
	endfunction

	initial begin
		sh_temp = '0;
		sh_plow = '0;
		sh_phigh = '0;
		sh_mixed = '0;
		sh_hum = '0;
		sh_has_hum = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		running = 1;

		// reset calibration: zero divisor, humidity absent
		raw_pending.push_back(raw_word('0, '0, '0));
		raw_pending.push_back(raw_word('1, '1, '1));
		raw_pending.push_back(raw_word(20'h55555, 20'hAAAAA, 16'h5A5A));
		wait_drained();

		// unknown indexes must not disturb anything
		write_reg(REG_SPARE_6, '1);
		write_reg(REG_SPARE_7, '1);
		raw_pending.push_back(raw_word(20'd415148, 20'd519888, 16'd30000));
		wait_drained();

		// typical part, field extremes, humidity clamp at both ends
		load_typical(1'b1);
		raw_pending.push_back(raw_word(20'd415148, 20'd519888, 16'd30000));
		raw_pending.push_back(raw_word('0, '0, '0));
		raw_pending.push_back(raw_word('1, '1, '1));
		raw_pending.push_back(raw_word('0, '1, '0));
		raw_pending.push_back(raw_word('1, '0, '1));
		raw_pending.push_back(raw_word(20'd415148, 20'd519888, 16'hFFFF));
		raw_pending.push_back(raw_word(20'd415148, 20'd519888, 16'd0));
		raw_pending.push_back(raw_word(20'hAAAAA, 20'h55555, 16'hA5A5));
		raw_pending.push_back(raw_word(20'd300000, 20'd400000, 16'd50000));
		wait_drained();

		// all calibration bits set
		for (int i = 0; i <= 5; i++)
			write_reg(cfg_reg_t'(i), '1);
		raw_pending.push_back(raw_word('0, '0, '0));
		raw_pending.push_back(raw_word('1, '1, '1));
		raw_pending.push_back(raw_word(20'd415148, 20'd519888, 16'd30000));
		wait_drained();

		// random phases across several calibration sets
		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 4)
				0: load_typical(1'b1);
				1: begin
					for (int i = 0; i <= 5; i++)
						write_reg(cfg_reg_t'(i), (ph == 5) ? '0 : '1);
				end
				2: begin
					for (int i = 0; i <= 5; i++)
						write_reg(cfg_reg_t'(i), rand64());
					write_reg(REG_SPARE_6, rand64());
				end
				default: load_typical(1'b0);
			endcase
			idle_on = (ph % 3) != 0;
			if (ph == 2)
				hold_left = 400;
			for (int k = 0; k < 175; k++)
				raw_pending.push_back(random_raw());
			wait_drained();
		end

		if (errors == 0)
			$display("[baro_sensor_compensation_core] OK");
		else
			$display("[baro_sensor_compensation_core] ERROR");
		$finish;
	end

endmodule
